### rtl/ppeb_pkg.sv
// ----------------------------------------------------------------------------
// ppeb_pkg
// Shared types and constants for the pulse pile-up event builder.
// ----------------------------------------------------------------------------
package ppeb_pkg;

   localparam int TIME_BITS   = 48;
   localparam int ENERGY_BITS = 32;
   localparam int PILE_BITS   = 8;
   localparam int WIN_BITS    = 24;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int REG_IDX_BITS  = 2;

   // Item kinds on the request channel.
   localparam logic ACTION_HIT   = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // Register indexes (byte address is four times the index).
   localparam logic [REG_IDX_BITS-1:0] REG_MERGE     = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_TRAPEZOID = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_HOLDOFF   = 2'd2;

   localparam logic [WIN_BITS-1:0] MERGE_RESET     = WIN_BITS'(1347);
   localparam logic [WIN_BITS-1:0] TRAPEZOID_RESET = WIN_BITS'(7000);
   localparam logic [WIN_BITS-1:0] HOLDOFF_RESET   = WIN_BITS'(7960);

   typedef struct packed {
      logic                   action;
      logic [TIME_BITS-1:0]   hit_time;
      logic [ENERGY_BITS-1:0] hit_energy;
      logic [PILE_BITS-1:0]   hit_pile;
   } req_item_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]   out_time;
      logic [ENERGY_BITS-1:0] out_energy;
      logic [PILE_BITS-1:0]   out_pile;
   } rsp_item_type;

   typedef struct packed {
      logic [WIN_BITS-1:0] merge_window;
      logic [WIN_BITS-1:0] trapezoid_window;
      logic [WIN_BITS-1:0] holdoff_window;
   } cfg_type;

   typedef struct packed {
      logic         emit;
      rsp_item_type item;
   } step_type;

endpackage

### rtl/ppeb_req_if.sv
// ----------------------------------------------------------------------------
// ppeb_req_if
// Hit request channel: valid/ready handshake with one hit or flush item.
// ----------------------------------------------------------------------------
interface ppeb_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic [ppeb_pkg::TIME_BITS-1:0]   hit_time;
   logic [ppeb_pkg::ENERGY_BITS-1:0] hit_energy;
   logic [ppeb_pkg::PILE_BITS-1:0]   hit_pile;

   modport source (output valid, action, hit_time, hit_energy, hit_pile, input ready);
   modport sink   (input valid, action, hit_time, hit_energy, hit_pile, output ready);
endinterface

### rtl/ppeb_rsp_if.sv
// ----------------------------------------------------------------------------
// ppeb_rsp_if
// Event result channel: valid/ready handshake with one emitted event.
// ----------------------------------------------------------------------------
interface ppeb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ppeb_pkg::TIME_BITS-1:0]   out_time;
   logic [ppeb_pkg::ENERGY_BITS-1:0] out_energy;
   logic [ppeb_pkg::PILE_BITS-1:0]   out_pile;

   modport source (output valid, out_time, out_energy, out_pile, input ready);
   modport sink   (input valid, out_time, out_energy, out_pile, output ready);
endinterface

### rtl/ppeb_csr.sv
// ----------------------------------------------------------------------------
// ppeb_csr
// APB-style register file holding the three pile-up windows.
// ----------------------------------------------------------------------------
module ppeb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ppeb_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ppeb_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ppeb_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output ppeb_pkg::cfg_type                  cfg
);

   ppeb_pkg::cfg_type                  cfg_ff, cfg_in;
   logic [ppeb_pkg::REG_IDX_BITS-1:0]  reg_idx;
   logic [ppeb_pkg::WIN_BITS-1:0]      wr_value;
   logic                               wr_go;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ppeb_pkg::CSR_ADDR_BITS-1:2];
   assign wr_value   = csr_pwdata[ppeb_pkg::WIN_BITS-1:0];
   assign wr_go      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_go) begin
         unique case (reg_idx)
            ppeb_pkg::REG_MERGE:     cfg_in.merge_window     = wr_value;
            ppeb_pkg::REG_TRAPEZOID: cfg_in.trapezoid_window = wr_value;
            ppeb_pkg::REG_HOLDOFF:   cfg_in.holdoff_window   = wr_value;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         ppeb_pkg::REG_MERGE:
            csr_prdata = ppeb_pkg::CSR_DATA_BITS'(cfg_ff.merge_window);
         ppeb_pkg::REG_TRAPEZOID:
            csr_prdata = ppeb_pkg::CSR_DATA_BITS'(cfg_ff.trapezoid_window);
         ppeb_pkg::REG_HOLDOFF:
            csr_prdata = ppeb_pkg::CSR_DATA_BITS'(cfg_ff.holdoff_window);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.merge_window     <= ppeb_pkg::MERGE_RESET;
         cfg_ff.trapezoid_window <= ppeb_pkg::TRAPEZOID_RESET;
         cfg_ff.holdoff_window   <= ppeb_pkg::HOLDOFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/ppeb_pend.sv
// ----------------------------------------------------------------------------
// ppeb_pend
// Pending-hit holder and the merge / reject / pile-up decision for one item.
// ----------------------------------------------------------------------------
module ppeb_pend (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_go,
   input  ppeb_pkg::req_item_type item,
   input  ppeb_pkg::cfg_type      cfg,
   output ppeb_pkg::step_type     step
);

   localparam int TB = ppeb_pkg::TIME_BITS;
   localparam int EB = ppeb_pkg::ENERGY_BITS;
   localparam int PB = ppeb_pkg::PILE_BITS;

   logic                 pend_valid_ff, pend_valid_in;
   logic [TB-1:0]        pend_time_ff, pend_time_in;
   logic [EB-1:0]        pend_energy_ff, pend_energy_in;
   logic [PB-1:0]        pend_pile_ff, pend_pile_in;

   logic [TB:0]          diff;
   logic                 early;
   logic                 in_merge, in_trap, in_hold;
   logic [TB-1:0]        avg_time;
   logic [EB:0]          energy_sum;
   logic [EB-1:0]        energy_sat;
   logic [PB:0]          pile_sum, pile_inc;
   logic [PB-1:0]        pile_sat, pile_inc_sat;

   // A hit earlier than the pending one counts as a zero gap.
   assign diff  = {1'b0, item.hit_time} - {1'b0, pend_time_ff};
   assign early = diff[TB];

   assign in_merge = early || (diff[TB-1:0] <= TB'(cfg.merge_window));
   assign in_trap  = early || (diff[TB-1:0] <= TB'(cfg.trapezoid_window));
   assign in_hold  = early || (diff[TB-1:0] <= TB'(cfg.holdoff_window));

   // Floor of the average without a wider adder.
   assign avg_time = (pend_time_ff >> 1) + (item.hit_time >> 1)
                   + TB'(pend_time_ff[0] & item.hit_time[0]);

   assign energy_sum   = {1'b0, pend_energy_ff} + {1'b0, item.hit_energy};
   assign energy_sat   = energy_sum[EB] ? '1 : energy_sum[EB-1:0];
   assign pile_sum     = {1'b0, pend_pile_ff} + {1'b0, item.hit_pile};
   assign pile_sat     = pile_sum[PB] ? '1 : pile_sum[PB-1:0];
   assign pile_inc     = {1'b0, item.hit_pile} + (PB+1)'(1);
   assign pile_inc_sat = pile_inc[PB] ? '1 : pile_inc[PB-1:0];

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_time_in   = pend_time_ff;
      pend_energy_in = pend_energy_ff;
      pend_pile_in   = pend_pile_ff;
      step.emit           = 1'b0;
      step.item.out_time   = pend_time_ff;
      step.item.out_energy = pend_energy_ff;
      step.item.out_pile   = pend_pile_ff;

      if (item.action == ppeb_pkg::ACTION_FLUSH) begin
         step.emit      = pend_valid_ff;
         pend_valid_in  = 1'b0;
      end else if (!pend_valid_ff) begin
         pend_valid_in  = 1'b1;
         pend_time_in   = item.hit_time;
         pend_energy_in = item.hit_energy;
         pend_pile_in   = item.hit_pile;
      end else if (in_merge) begin
         pend_time_in   = avg_time;
         pend_energy_in = energy_sat;
         pend_pile_in   = pile_sat;
      end else if (in_trap) begin
         step.emit            = 1'b1;
         step.item.out_energy = '0;
         pend_time_in         = item.hit_time;
         pend_energy_in       = '0;
         pend_pile_in         = item.hit_pile;
      end else if (in_hold) begin
         step.emit      = 1'b1;
         pend_time_in   = item.hit_time;
         pend_energy_in = '0;
         pend_pile_in   = pile_inc_sat;
      end else begin
         step.emit      = 1'b1;
         pend_time_in   = item.hit_time;
         pend_energy_in = item.hit_energy;
         pend_pile_in   = item.hit_pile;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (step_go) begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         pend_time_ff   <= pend_time_in;
         pend_energy_ff <= pend_energy_in;
         pend_pile_ff   <= pend_pile_in;
      end
   end

endmodule

### rtl/pulse_pileup_event_builder.sv
// ----------------------------------------------------------------------------
// pulse_pileup_event_builder
// Pile-up rejection and merging for a time-ordered digitizer hit stream.
// ----------------------------------------------------------------------------
// Hits enter on req_if (valid/ready); action selects a new hit or a flush of
// the pending hit. Finished events leave on rsp_if (valid/ready). The three
// windows are set through the csr_ APB port at byte addresses 0, 4 and 8 and
// should only be changed while the stream is idle.
// An accepted item is held in an input register and decided against the
// pending hit once the output register can take its event; the event (if
// any) is registered there and shows on rsp_if. One item per cycle is
// sustained while the receiver does not stall; the rate is set by the decision
// path (one 48-bit subtract, the window compares and the saturating adders).
// A new hit yields no event when it merges or when nothing was pending; a
// flush yields one only if a hit is pending.
// Reset empties the pending holder and both pipeline registers and restores
// the default windows. When the receiver stalls, the event waits in the
// output register, one more item is taken into the input register, and
// req_if.ready then drops until the output frees up.
// ----------------------------------------------------------------------------
module pulse_pileup_event_builder (
   input  logic                               clock,
   input  logic                               reset,
   ppeb_req_if.sink                           req_if,
   ppeb_rsp_if.source                         rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ppeb_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ppeb_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ppeb_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   ppeb_pkg::cfg_type      cfg;
   ppeb_pkg::step_type     step;

   logic                   in_valid_ff, in_valid_in;
   ppeb_pkg::req_item_type in_item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   ppeb_pkg::rsp_item_type rsp_item_ff;
   logic                   req_go, step_go;

   ppeb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ppeb_pend u_pend (
      .clock   (clock),
      .reset   (reset),
      .step_go (step_go),
      .item    (in_item_ff),
      .cfg     (cfg),
      .step    (step)
   );

   // The held item is decided once the output register can take its event.
   assign step_go       = in_valid_ff & (~rsp_valid_ff | rsp_if.ready);
   assign req_if.ready  = ~in_valid_ff | step_go;
   assign req_go        = req_if.valid & req_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_time   = rsp_item_ff.out_time;
   assign rsp_if.out_energy = rsp_item_ff.out_energy;
   assign rsp_if.out_pile   = rsp_item_ff.out_pile;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_go) begin
         in_valid_in = 1'b1;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_go) begin
         rsp_valid_in = step.emit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         in_item_ff.action     <= req_if.action;
         in_item_ff.hit_time   <= req_if.hit_time;
         in_item_ff.hit_energy <= req_if.hit_energy;
         in_item_ff.hit_pile   <= req_if.hit_pile;
      end
      if (step_go && step.emit) begin
         rsp_item_ff <= step.item;
      end
   end

endmodule

### dv/pulse_pileup_event_builder_tb.sv
// ----------------------------------------------------------------------------
// pulse_pileup_event_builder_tb
// Self-checking testbench for the pulse pile-up event builder. A clocked
// driver sends hit and flush items from a queue, and a built-in pile-up
// predictor works out the event each accepted item should emit. A clocked
// monitor compares every emitted event with the oldest predicted one. The
// run steps through several window settings, written over APB and read back,
// and through several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module pulse_pileup_event_builder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ppeb_pkg::REG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT   = 2000;

   logic clock = 1'b0;
   logic reset;

   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [ppeb_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [ppeb_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [ppeb_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   ppeb_req_if req_if ();
   ppeb_rsp_if rsp_if ();

   pulse_pileup_event_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Items waiting to be sent and events waiting to come out.
   ppeb_pkg::req_item_type hit_q[$];
   ppeb_pkg::rsp_item_type event_q[$];

   // Predictor state: window settings and the pending hit.
   ppeb_pkg::cfg_type                win;
   logic                             pend_valid;
   logic [ppeb_pkg::TIME_BITS-1:0]   pend_time;
   logic [ppeb_pkg::ENERGY_BITS-1:0] pend_energy;
   logic [ppeb_pkg::PILE_BITS-1:0]   pend_pile;

   logic [ppeb_pkg::TIME_BITS-1:0] gen_time;
   ppeb_pkg::req_item_type         cur_hit;
   int unsigned                    send_idle_pct;
   int unsigned                    stall_pct;
   int unsigned                    mismatch_count;
   int unsigned                    stuck_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic add_item(input ppeb_pkg::req_item_type it);
      hit_q = {hit_q, it};
   endtask

   task automatic add_event(input ppeb_pkg::rsp_item_type ev);
      event_q = {event_q, ev};
   endtask

   // ------------------------------------------------------------------------
   // Pile-up predictor
   // ------------------------------------------------------------------------
   function automatic logic [ppeb_pkg::PILE_BITS-1:0] sat_pile(
         input logic [ppeb_pkg::PILE_BITS-1:0] a,
         input logic [ppeb_pkg::PILE_BITS-1:0] b);
      logic [ppeb_pkg::PILE_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[ppeb_pkg::PILE_BITS] ? '1 : sum[ppeb_pkg::PILE_BITS-1:0];
   endfunction

   task automatic load_pending(input logic [ppeb_pkg::TIME_BITS-1:0] t,
                               input logic [ppeb_pkg::ENERGY_BITS-1:0] e,
                               input logic [ppeb_pkg::PILE_BITS-1:0] p);
      pend_valid  = 1'b1;
      pend_time   = t;
      pend_energy = e;
      pend_pile   = p;
   endtask

   task automatic pileup_decide(input ppeb_pkg::req_item_type hit);
      logic [ppeb_pkg::TIME_BITS-1:0] gap;
      logic [ppeb_pkg::TIME_BITS-1:0] avg;
      logic [ppeb_pkg::ENERGY_BITS:0] esum;
      ppeb_pkg::rsp_item_type         ev;
      ev.out_time   = pend_time;
      ev.out_energy = pend_energy;
      ev.out_pile   = pend_pile;
      if (hit.action == ppeb_pkg::ACTION_FLUSH) begin
         if (pend_valid) add_event(ev);
         load_pending('0, '0, '0);
         pend_valid = 1'b0;
         return;
      end
      if (!pend_valid) begin
         load_pending(hit.hit_time, hit.hit_energy, hit.hit_pile);
         return;
      end
      // A hit earlier than the pending one counts as a zero gap.
      gap = (hit.hit_time >= pend_time) ? hit.hit_time - pend_time : '0;
      if (gap <= ppeb_pkg::TIME_BITS'(win.merge_window)) begin
         avg  = (pend_time >> 1) + (hit.hit_time >> 1)
              + ppeb_pkg::TIME_BITS'(pend_time[0] & hit.hit_time[0]);
         esum = {1'b0, pend_energy} + {1'b0, hit.hit_energy};
         load_pending(avg,
                      esum[ppeb_pkg::ENERGY_BITS] ? '1 : esum[ppeb_pkg::ENERGY_BITS-1:0],
                      sat_pile(pend_pile, hit.hit_pile));
      end else if (gap <= ppeb_pkg::TIME_BITS'(win.trapezoid_window)) begin
         ev.out_energy = '0;
         add_event(ev);
         load_pending(hit.hit_time, '0, hit.hit_pile);
      end else if (gap <= ppeb_pkg::TIME_BITS'(win.holdoff_window)) begin
         add_event(ev);
         load_pending(hit.hit_time, '0, sat_pile(hit.hit_pile, 8'd1));
      end else begin
         add_event(ev);
         load_pending(hit.hit_time, hit.hit_energy, hit.hit_pile);
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: one item per transfer, random idle cycles between items.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) pileup_decide(cur_hit);
         if (!req_if.valid || req_if.ready) begin
            if (hit_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               cur_hit = hit_q.pop_front();
               req_if.valid      <= 1'b1;
               req_if.action     <= cur_hit.action;
               req_if.hit_time   <= cur_hit.hit_time;
               req_if.hit_energy <= cur_hit.hit_energy;
               req_if.hit_pile   <= cur_hit.hit_pile;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each event transfer against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      ppeb_pkg::rsp_item_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (event_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected event time=%0d energy=%0d pile=%0d", $time,
                        rsp_if.out_time, rsp_if.out_energy, rsp_if.out_pile);
            end else begin
               want = event_q.pop_front();
               if (rsp_if.out_time !== want.out_time) begin
                  mismatch_count++;
                  $display("%0t: out_time expected %0d actual %0d", $time,
                           want.out_time, rsp_if.out_time);
               end
               if (rsp_if.out_energy !== want.out_energy) begin
                  mismatch_count++;
                  $display("%0t: out_energy expected %0d actual %0d", $time,
                           want.out_energy, rsp_if.out_energy);
               end
               if (rsp_if.out_pile !== want.out_pile) begin
                  mismatch_count++;
                  $display("%0t: out_pile expected %0d actual %0d", $time,
                           want.out_pile, rsp_if.out_pile);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[pulse_pileup_event_builder] ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // APB access
   // ------------------------------------------------------------------------
   task automatic csr_access(input logic write,
                             input logic [ppeb_pkg::REG_IDX_BITS-1:0] idx,
                             input logic [ppeb_pkg::CSR_DATA_BITS-1:0] data,
                             output logic [ppeb_pkg::CSR_DATA_BITS-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= ppeb_pkg::CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_write(input logic [ppeb_pkg::REG_IDX_BITS-1:0] idx,
                            input logic [ppeb_pkg::WIN_BITS-1:0] value);
      logic [ppeb_pkg::CSR_DATA_BITS-1:0] unused;
      // Random upper bits: only the low 24 bits of a window are kept.
      csr_access(1'b1, idx, {8'($urandom_range(255, 0)), value}, unused);
      case (idx)
         ppeb_pkg::REG_MERGE:     win.merge_window     = value;
         ppeb_pkg::REG_TRAPEZOID: win.trapezoid_window = value;
         ppeb_pkg::REG_HOLDOFF:   win.holdoff_window   = value;
         default: ;
      endcase
   endtask

   task automatic csr_check(input logic [ppeb_pkg::REG_IDX_BITS-1:0] idx,
                            input logic [ppeb_pkg::WIN_BITS-1:0] want);
      logic [ppeb_pkg::CSR_DATA_BITS-1:0] got;
      csr_access(1'b0, idx, '0, got);
      if (got !== ppeb_pkg::CSR_DATA_BITS'(want)) begin
         mismatch_count++;
         $display("%0t: register %0d expected %0d actual %0d", $time, idx, want, got);
      end
   endtask

   task automatic set_windows(input logic [ppeb_pkg::WIN_BITS-1:0] m,
                              input logic [ppeb_pkg::WIN_BITS-1:0] t,
                              input logic [ppeb_pkg::WIN_BITS-1:0] h);
      csr_write(ppeb_pkg::REG_MERGE, m);
      csr_write(ppeb_pkg::REG_TRAPEZOID, t);
      csr_write(ppeb_pkg::REG_HOLDOFF, h);
      csr_check(ppeb_pkg::REG_MERGE, win.merge_window);
      csr_check(ppeb_pkg::REG_TRAPEZOID, win.trapezoid_window);
      csr_check(ppeb_pkg::REG_HOLDOFF, win.holdoff_window);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   function automatic logic [ppeb_pkg::TIME_BITS-1:0] rand_time();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ppeb_pkg::TIME_BITS-1:0];
   endfunction

   task automatic push_hit(input logic [ppeb_pkg::TIME_BITS-1:0] t,
                           input logic [ppeb_pkg::ENERGY_BITS-1:0] e,
                           input logic [ppeb_pkg::PILE_BITS-1:0] p);
      ppeb_pkg::req_item_type h;
      h.action     = ppeb_pkg::ACTION_HIT;
      h.hit_time   = t;
      h.hit_energy = e;
      h.hit_pile   = p;
      add_item(h);
   endtask

   task automatic push_flush();
      ppeb_pkg::req_item_type h;
      h.action     = ppeb_pkg::ACTION_FLUSH;
      h.hit_time   = rand_time();
      h.hit_energy = $urandom;
      h.hit_pile   = 8'($urandom_range(255, 0));
      add_item(h);
   endtask

   // Picks the next gap so that each window test gets its share of hits.
   function automatic ppeb_pkg::req_item_type make_hit();
      ppeb_pkg::req_item_type         h;
      int unsigned                    pick;
      logic [ppeb_pkg::TIME_BITS-1:0] gap;
      logic [ppeb_pkg::TIME_BITS-1:0] m;
      logic [ppeb_pkg::TIME_BITS-1:0] tz;
      logic [ppeb_pkg::TIME_BITS-1:0] hd;
      m    = ppeb_pkg::TIME_BITS'(win.merge_window);
      tz   = ppeb_pkg::TIME_BITS'(win.trapezoid_window);
      hd   = ppeb_pkg::TIME_BITS'(win.holdoff_window);
      pick = $urandom_range(99, 0);
      h.action = ppeb_pkg::ACTION_HIT;
      case ($urandom_range(9, 0))
         0:       h.hit_energy = '1;
         1:       h.hit_energy = '0;
         default: h.hit_energy = $urandom;
      endcase
      case ($urandom_range(9, 0))
         0:       h.hit_pile = '1;
         1:       h.hit_pile = '0;
         default: h.hit_pile = 8'($urandom_range(255, 0));
      endcase
      if (pick < 6) begin
         h.action   = ppeb_pkg::ACTION_FLUSH;
         h.hit_time = rand_time();
         return h;
      end
      if (pick < 22) gap = ppeb_pkg::TIME_BITS'($urandom_range(32'(m), 0));
      else if (pick < 40) gap = ppeb_pkg::TIME_BITS'($urandom_range(32'(m) + 1, 32'(tz)));
      else if (pick < 58) gap = ppeb_pkg::TIME_BITS'($urandom_range(32'(tz) + 1, 32'(hd)));
      else if (pick < 78) gap = hd + 1 + ppeb_pkg::TIME_BITS'($urandom_range(20000, 0));
      else if (pick < 84) gap = -ppeb_pkg::TIME_BITS'($urandom_range(5000, 1));
      else if (pick < 90) gap = rand_time();
      else begin
         case ($urandom_range(5, 0))
            0:       gap = m;
            1:       gap = m + 1;
            2:       gap = tz;
            3:       gap = tz + 1;
            4:       gap = hd;
            default: gap = hd + 1;
         endcase
      end
      gen_time   = gen_time + gap;
      h.hit_time = gen_time;
      return h;
   endfunction

   task automatic add_random(input int unsigned n);
      repeat (n) add_item(make_hit());
   endtask

   task automatic wait_results();
      while (hit_q.size() > 0 || req_if.valid || event_q.size() > 0) @(posedge clock);
   endtask

   // A merged hit emits nothing, so the block may still be busy after the last event.
   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic directed_items();
      logic [ppeb_pkg::TIME_BITS-1:0] t;
      ppeb_pkg::req_item_type         f;
      push_flush();                                    // flush with empty holder
      push_hit(48'd1001, '1, 8'hFF);
      push_hit(48'd1001 + ppeb_pkg::MERGE_RESET, 32'd7, 8'd2);  // merge, both sums saturate
      push_hit(48'd500, 32'd1, 8'd0);                  // earlier than pending
      push_flush();
      push_flush();
      t = 48'd10001;
      push_hit(t, 32'd100, 8'd1);
      t = t + ppeb_pkg::TRAPEZOID_RESET;
      push_hit(t, 32'd200, 8'd2);                      // trapezoid rejection
      t = t + ppeb_pkg::HOLDOFF_RESET;
      push_hit(t, 32'd300, 8'hFF);                     // hold-off, pile saturates
      t = t + ppeb_pkg::HOLDOFF_RESET + 1;
      push_hit(t, 32'd400, 8'd4);                      // clean pulse
      t = t + ppeb_pkg::MERGE_RESET + 1;
      push_hit(t, 32'd500, 8'd5);
      t = t + ppeb_pkg::TRAPEZOID_RESET + 1;
      push_hit(t, 32'd600, 8'd6);
      push_flush();
      push_hit('1, '0, '0);
      push_hit('1, '1, 8'hFF);                         // merge at the top of time
      push_hit('0, 32'h5555_AAAA, 8'h55);
      f.action     = ppeb_pkg::ACTION_FLUSH;
      f.hit_time   = '1;
      f.hit_energy = '1;
      f.hit_pile   = '1;
      add_item(f);
      push_hit(48'd7, 32'hAAAA_5555, 8'hAA);
      push_flush();
   endtask

   initial begin
      logic [ppeb_pkg::WIN_BITS-1:0] a;
      logic [ppeb_pkg::WIN_BITS-1:0] b;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = ppeb_pkg::ACTION_HIT;
      req_if.hit_time   = '0;
      req_if.hit_energy = '0;
      req_if.hit_pile   = '0;
      rsp_if.ready      = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      win.merge_window     = ppeb_pkg::MERGE_RESET;
      win.trapezoid_window = ppeb_pkg::TRAPEZOID_RESET;
      win.holdoff_window   = ppeb_pkg::HOLDOFF_RESET;
      pend_valid     = 1'b0;
      pend_time      = '0;
      pend_energy    = '0;
      pend_pile      = '0;
      gen_time       = '0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      mismatch_count = 0;
      stuck_cycles   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset windows, no idling.
      csr_check(ppeb_pkg::REG_MERGE, win.merge_window);
      csr_check(ppeb_pkg::REG_TRAPEZOID, win.trapezoid_window);
      csr_check(ppeb_pkg::REG_HOLDOFF, win.holdoff_window);
      directed_items();
      add_random(60);
      settle();

      // All windows closed: only equal or earlier times merge. Sender idles.
      set_windows('0, '0, '0);
      send_idle_pct = 48;
      add_random(70);
      push_flush();
      settle();

      // All windows fully open: most hits merge. Receiver stalls.
      set_windows('1, '1, '1);
      send_idle_pct = 0;
      stall_pct     = 48;
      repeat (10) begin
         add_random(7);
         push_flush();
      end
      settle();

      // Windows out of order, both sides idle.
      set_windows(24'd5000, 24'd300, 24'd2000);
      send_idle_pct = 30;
      stall_pct     = 30;
      add_random(70);
      push_flush();
      settle();

      // Ordered random windows; the sender holds off halfway until all events are out.
      a = 24'($urandom_range(3000, 0));
      b = a + 24'($urandom_range(8000, 0));
      set_windows(a, b, b + 24'($urandom_range(4000, 0)));
      add_random(35);
      wait_results();
      add_random(35);
      settle();

      // A write past the last register must change nothing.
      csr_write(REG_UNUSED, 24'hFFFFFF);
      csr_check(ppeb_pkg::REG_MERGE, win.merge_window);
      csr_check(ppeb_pkg::REG_TRAPEZOID, win.trapezoid_window);
      csr_check(ppeb_pkg::REG_HOLDOFF, win.holdoff_window);
      set_windows(24'($urandom_range(20000, 0)), 24'($urandom_range(20000, 0)),
                  24'($urandom_range(20000, 0)));
      send_idle_pct = 0;
      stall_pct     = 0;
      add_random(70);
      settle();

      set_windows(ppeb_pkg::MERGE_RESET, ppeb_pkg::TRAPEZOID_RESET,
                  ppeb_pkg::HOLDOFF_RESET);
      send_idle_pct = 30;
      stall_pct     = 30;
      add_random(70);
      push_flush();
      wait_results();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && event_q.size() == 0) begin
         $display("[pulse_pileup_event_builder] OK");
      end else begin
         $display("[pulse_pileup_event_builder] ERROR");
      end
      $finish;
   end

endmodule
